[rtl/wla_pkg.sv]
// Shared types and constants of the windowed load average block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package wla_pkg;

  localparam int TICK_W      = 32;
  localparam int CNT_W       = 32;
  localparam int AVG_W       = 28;
  localparam int TASK_IN_W   = 16;
  localparam int TASK_W      = TASK_IN_W + 1;
  // Covers the longest window at the highest tick rate (900000 ticks).
  localparam int ELAPSED_W   = 20;
  localparam int NUM_WIN     = 3;
  localparam int DIV_BITS    = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int WIN_SHORT  = 0;
  localparam int WIN_MEDIUM = 1;
  localparam int WIN_LONG   = 2;

  localparam logic [AVG_W-1:0] AVG_MAX = '1;

  typedef struct packed {
    logic [TICK_W-1:0]    now_ticks;
    logic [TASK_IN_W-1:0] running_tasks;
    logic [TASK_IN_W-1:0] blocked_tasks;
  } in_item_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg_short;
    logic [AVG_W-1:0] avg_medium;
    logic [AVG_W-1:0] avg_long;
    logic             did_update;
    logic [CNT_W-1:0] event_count;
  } out_item_t;

  // One classified sample as it travels from the front end to the back end.
  typedef struct packed {
    logic                 upd;
    logic [NUM_WIN-1:0]   past_win;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TASK_W-1:0]    tasks;
    logic [CNT_W-1:0]     event_count;
  } sample_t;

endpackage

`default_nettype wire

[rtl/wla_in_if.sv]
// Sample event channel: valid/ready handshake with an in_item_t payload.
// Depends on wla_pkg.
`default_nettype none

interface wla_in_if;
  logic               valid;
  logic               ready;
  wla_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/wla_out_if.sv]
// Result channel: valid/ready handshake with an out_item_t payload.
// Depends on wla_pkg.
`default_nettype none

interface wla_out_if;
  logic               valid;
  logic               ready;
  wla_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/windowed_load_average.sv]
// Windowed load average: 1, 5 and 15 minute averages of running+blocked tasks.
// Uses wla_pkg, wla_in_if, wla_out_if, wla_front, wla_queue and wla_back.
//
// in_ch carries one sample beat per handshake (valid && ready): the current
// tick count and the running and blocked task counts. out_ch returns exactly
// one result beat per sample, in order: the three averages after the sample
// (FRACTION_BITS fraction bits, saturated to 28 bits), did_update and the
// running event count.
// The front end computes the elapsed ticks, decides whether the averages are
// due and bumps the event count; it takes one beat per cycle while the
// four-entry queue has room. The back end drains the queue in order.
// A beat that does not update the averages moves from the queue into the
// output register while the back end is idle and out_ch is not stalled, one
// per cycle. A beat that updates occupies the back end through its pop, a
// multiply stage, a sum stage, NSTEPS long-division steps of 4 quotient bits
// each against the window length, then the output load. NSTEPS is 8 with the
// default parameters; the back end takes no new beat until that output load,
// and the queue absorbs bursts while the divider works.
// Reset clears the averages, the last update tick, the event count and the
// queue. When out_ch stalls, the output register holds its beat, the back end
// halts at its next result, the queue fills and in_ch.ready drops when full.
`default_nettype none

module windowed_load_average #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int FRACTION_BITS    = 11
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wla_in_if.sink     in_ch,
  wla_out_if.source  out_ch
);

  logic             q_push;
  logic             q_ready;
  wla_pkg::sample_t q_data;
  logic             head_valid;
  logic             head_pop;
  wla_pkg::sample_t head_data;

  // Classify each beat and keep the last update tick.
  wla_front #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  // Hold classified beats while the back end runs a division.
  wla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (head_pop)
  );

  // Recompute the averages and drive the output register.
  wla_back #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

[rtl/wla_front.sv]
// Front end: accepts sample beats, measures elapsed ticks and classifies them.
// Depends on wla_pkg and wla_in_if.
`default_nettype none

module wla_front #(
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  wla_in_if.sink         in_ch,
  input  wire logic      q_ready,
  output logic           q_push,
  output wla_pkg::sample_t q_data
);

  localparam int TW = wla_pkg::TICK_W;
  localparam int CW = wla_pkg::CNT_W;
  localparam int KW = wla_pkg::TASK_W;

  localparam logic [TW-1:0] MIN_GAP  = TW'(5 * TICKS_PER_SECOND);
  localparam logic [TW-1:0] WIN_S    = TW'(60 * TICKS_PER_SECOND);
  localparam logic [TW-1:0] WIN_M    = TW'(300 * TICKS_PER_SECOND);
  localparam logic [TW-1:0] WIN_L    = TW'(900 * TICKS_PER_SECOND);

  logic [TW-1:0] last_tick_r, last_tick_nxt;
  logic [CW-1:0] events_r, events_nxt;
  logic [CW-1:0] events_inc;
  logic [TW-1:0] elapsed;
  logic          upd;

  assign elapsed    = in_ch.data.now_ticks - last_tick_r;
  assign upd        = (elapsed >= MIN_GAP);
  assign events_inc = events_r + CW'(1);

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  always_comb begin
    q_data.upd                         = upd;
    q_data.past_win[wla_pkg::WIN_SHORT]  = (elapsed >= WIN_S);
    q_data.past_win[wla_pkg::WIN_MEDIUM] = (elapsed >= WIN_M);
    q_data.past_win[wla_pkg::WIN_LONG]   = (elapsed >= WIN_L);
    q_data.elapsed                     = elapsed[wla_pkg::ELAPSED_W-1:0];
    q_data.tasks                       = {1'b0, in_ch.data.running_tasks}
                                       + {1'b0, in_ch.data.blocked_tasks};
    q_data.event_count                 = events_inc;
  end

  // Advance the update tick only for beats that trigger a recompute.
  always_comb begin
    last_tick_nxt = (q_push && upd) ? in_ch.data.now_ticks : last_tick_r;
    events_nxt    = q_push ? events_inc : events_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
      events_r    <= '0;
    end else begin
      last_tick_r <= last_tick_nxt;
      events_r    <= events_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/wla_queue.sv]
// Short register queue that decouples the front end from the back end.
// Depends on wla_pkg.
`default_nettype none

module wla_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wla_pkg::sample_t      push_data,
  output logic                  push_ready,
  output logic                  head_valid,
  output wla_pkg::sample_t      head_data,
  input  wire logic             pop
);

  localparam int DEPTH = wla_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  wla_pkg::sample_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign push_ready = (count_r != (PTR_W+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + (PTR_W+1)'(1);
      2'b01:   count_nxt = count_r - (PTR_W+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/wla_back.sv]
// Back end: holds the three averages and recomputes them with a multiply stage
// and a constant-divisor long divider per window. Depends on wla_pkg, wla_out_if.
`default_nettype none

module wla_back #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int FRACTION_BITS    = 11
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wla_pkg::sample_t head_data,
  output logic             head_pop,
  wla_out_if.source        out_ch
);

  localparam int AW     = wla_pkg::AVG_W;
  localparam int KW     = wla_pkg::TASK_W;
  localparam int CW     = wla_pkg::CNT_W;
  localparam int NW_WIN = wla_pkg::NUM_WIN;
  localparam int DB     = wla_pkg::DIV_BITS;

  localparam int W_SHORT  = 60 * TICKS_PER_SECOND;
  localparam int W_MEDIUM = 300 * TICKS_PER_SECOND;
  localparam int W_LONG   = 900 * TICKS_PER_SECOND;
  localparam int WW       = $clog2(W_LONG + 1);

  // tasks << FRACTION_BITS; the quotient stays below 2^QB
  localparam int SUM_W  = KW + FRACTION_BITS;
  localparam int QB     = ((SUM_W > AW) ? SUM_W : AW) + 1;
  localparam int QP     = ((QB + DB - 1) / DB) * DB;
  localparam int NSTEPS = QP / DB;
  localparam int STEP_W = $clog2(NSTEPS);
  localparam int NUM_W  = WW + QP;
  localparam int P1_W   = WW + KW;
  localparam int P2_W   = WW + AW;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_DIV, S_OUT} state_t;

  state_t                state_r;
  logic [STEP_W-1:0]     step_r;
  logic                  out_valid_r;
  wla_pkg::out_item_t    out_data_r;

  logic [WW-1:0]         e_r;
  logic [KW-1:0]         tasks_r;
  logic [NW_WIN-1:0]     past_r;
  logic [CW-1:0]         cnt_r;

  logic [AW-1:0]         avg_cur [NW_WIN];
  logic [AW-1:0]         avg_new [NW_WIN];

  logic                  out_free;
  logic                  out_fire;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Take update beats at once; non-update beats need the output register.
  assign head_pop = (state_r == S_IDLE) && head_valid && (head_data.upd || out_free);

  always_ff @(posedge clk) begin
    if (head_pop && head_data.upd) begin
      e_r     <= head_data.elapsed[WW-1:0];
      tasks_r <= head_data.tasks;
      past_r  <= head_data.past_win;
      cnt_r   <= head_data.event_count;
    end
  end

  for (genvar g = 0; g < NW_WIN; g++) begin : g_lane
    localparam int WIN = (g == wla_pkg::WIN_SHORT)  ? W_SHORT :
                         (g == wla_pkg::WIN_MEDIUM) ? W_MEDIUM : W_LONG;
    localparam logic [WW-1:0] WIN_V = WW'(WIN);

    logic [P1_W-1:0]  p1_r;
    logic [P2_W-1:0]  p2_r;
    logic [WW-1:0]    rem_r, rem_nxt;
    logic [QP-1:0]    quo_r, quo_nxt;
    logic [AW-1:0]    avg_r;
    logic [WW-1:0]    left_v;
    logic [NUM_W-1:0] dividend;
    logic [WW:0]      trial;
    logic [QP-1:0]    full_v;

    assign left_v   = WIN_V - e_r;
    assign dividend = (NUM_W'(p1_r) << FRACTION_BITS) + NUM_W'(p2_r);
    assign full_v   = QP'({tasks_r, {FRACTION_BITS{1'b0}}});

    // Restoring division by the window length, DB quotient bits per cycle.
    always_comb begin
      rem_nxt = rem_r;
      quo_nxt = quo_r;
      trial   = '0;
      for (int k = 0; k < DB; k++) begin
        trial = {rem_nxt, quo_nxt[QP-1]};
        if (trial >= {1'b0, WIN_V}) begin
          rem_nxt = WW'(trial - {1'b0, WIN_V});
          quo_nxt = {quo_nxt[QP-2:0], 1'b1};
        end else begin
          rem_nxt = trial[WW-1:0];
          quo_nxt = {quo_nxt[QP-2:0], 1'b0};
        end
      end
    end

    // Saturate to the average width; a long gap takes the task count outright.
    always_comb begin
      if (past_r[g]) begin
        avg_new[g] = (full_v > QP'(wla_pkg::AVG_MAX)) ? wla_pkg::AVG_MAX : full_v[AW-1:0];
      end else begin
        avg_new[g] = (quo_r > QP'(wla_pkg::AVG_MAX)) ? wla_pkg::AVG_MAX : quo_r[AW-1:0];
      end
    end

    assign avg_cur[g] = avg_r;

    always_ff @(posedge clk) begin
      case (state_r)
        S_MUL: begin
          p1_r <= P1_W'(e_r) * P1_W'(tasks_r);
          p2_r <= P2_W'(left_v) * P2_W'(avg_r);
        end
        S_SUM: begin
          rem_r <= dividend[NUM_W-1:QP];
          quo_r <= dividend[QP-1:0];
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
        end
        default: begin
          rem_r <= rem_r;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        avg_r <= '0;
      end else if (state_r == S_OUT && out_free) begin
        avg_r <= avg_new[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head_valid && head_data.upd) begin
            state_r <= S_MUL;
          end else if (head_valid && out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.avg_short   <= avg_cur[wla_pkg::WIN_SHORT];
            out_data_r.avg_medium  <= avg_cur[wla_pkg::WIN_MEDIUM];
            out_data_r.avg_long    <= avg_cur[wla_pkg::WIN_LONG];
            out_data_r.did_update  <= 1'b0;
            out_data_r.event_count <= head_data.event_count;
          end
        end
        S_MUL: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          state_r <= S_DIV;
          step_r  <= STEP_W'(NSTEPS - 1);
        end
        S_DIV: begin
          if (step_r == '0) begin
            state_r <= S_OUT;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.avg_short   <= avg_new[wla_pkg::WIN_SHORT];
            out_data_r.avg_medium  <= avg_new[wla_pkg::WIN_MEDIUM];
            out_data_r.avg_long    <= avg_new[wla_pkg::WIN_LONG];
            out_data_r.did_update  <= 1'b1;
            out_data_r.event_count <= cnt_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_OUT) |=> $stable({avg_cur[0], avg_cur[1], avg_cur[2]}))
    else $error("averages changed outside the commit state");

  a_count_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> !out_fire
                 || (out_ch.data.event_count == $past(out_ch.data.event_count) + CW'(1)))
    else $error("event count of consecutive results not contiguous");

  a_no_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> !(out_fire && !out_ch.data.did_update)
                 || (out_ch.data.avg_long == $past(out_ch.data.avg_long)))
    else $error("average moved on a result without update");

  a_quick_path: assert property (@(posedge clk) disable iff (!rst_n)
    (head_pop && !head_data.upd) |=> (out_ch.valid && !out_ch.data.did_update))
    else $error("non-update beat did not reach the output register");

endmodule

`default_nettype wire
